FILE: rtl/core/erb_band_feature_normalizer_unit_macros.svh
// ----------------------------------------------------------------------------
// erb_band_feature_normalizer_unit_macros
// Assertion macros for the ERB band feature normalizer.
// ----------------------------------------------------------------------------
`ifndef ERB_BAND_FEATURE_NORMALIZER_UNIT_MACROS_SVH
`define ERB_BAND_FEATURE_NORMALIZER_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define EBN_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define EBN_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);
`else
`define EBN_ASSERT(lbl, clk, rstn, prop, msg)
`define EBN_ASSERT_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

FILE: rtl/core/ebn_pkg.sv
// ----------------------------------------------------------------------------
// ebn_pkg
// Shared types, constants and tables of the ERB band normalizer.
// ----------------------------------------------------------------------------
package ebn_pkg;
  localparam int NumBands = 32;
  localparam int BandW = $clog2(NumBands);
  localparam int MeanAw = BandW;
  localparam logic [47:0] PowerMax = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] EpsQ44 = 48'd1759;
  localparam logic [17:0] DbPerLog2Q16 = 18'd197284;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 16;
  localparam logic [CfgIdxW-1:0] CfgSmoothing = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDbEnable = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNormDiv = 2'd2;

  typedef struct packed {
    logic [23:0] bin_re;
    logic [23:0] bin_im;
    logic        frame_start;
  } bin_t;

  typedef struct packed {
    logic [4:0]  band_index;
    logic [15:0] band_feature;
    logic        last_band;
  } feat_t;

  // Band job handed from accumulator to normalizer.
  typedef struct packed {
    logic [BandW-1:0] band;
    logic [47:0]      power;
    logic [6:0]       width;
    logic             last;
  } job_t;

  function automatic logic [6:0] band_width(input logic [BandW-1:0] b);
    logic [6:0] w;
    unique case (b)
      5'd13, 5'd14: w = 7'd5;
      5'd15, 5'd16: w = 7'd7;
      5'd17: w = 7'd8;
      5'd18: w = 7'd10;
      5'd19: w = 7'd12;
      5'd20: w = 7'd13;
      5'd21: w = 7'd15;
      5'd22: w = 7'd18;
      5'd23: w = 7'd20;
      5'd24: w = 7'd24;
      5'd25: w = 7'd28;
      5'd26: w = 7'd31;
      5'd27: w = 7'd37;
      5'd28: w = 7'd42;
      5'd29: w = 7'd50;
      5'd30: w = 7'd56;
      5'd31: w = 7'd67;
      default: w = 7'd2;
    endcase
    return w;
  endfunction

  // Reset value of the running mean, Q8.8.
  function automatic logic [15:0] mean_reset(input logic [BandW-1:0] b);
    logic [31:0] t;
    t = 32'd15360 + (32'd15360 * 32'(b) + 32'(NumBands - 1)) / 32'(2 * (NumBands - 1));
    return 16'(-t);
  endfunction

  function automatic logic [15:0] clamp16(input logic signed [47:0] v);
    if (v > 48'sd32767) return 16'h7FFF;
    if (v < -48'sd32768) return 16'h8000;
    return v[15:0];
  endfunction
endpackage

FILE: rtl/core/ebn_stream_if.sv
// ----------------------------------------------------------------------------
// ebn_stream_if
// Valid/ready channel carrying one payload.
// ----------------------------------------------------------------------------
interface ebn_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/core/ebn_accum.sv
// ----------------------------------------------------------------------------
// ebn_accum
// Per-band power accumulator: bin power, saturating sum, band closing.
// ----------------------------------------------------------------------------
module ebn_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  ebn_pkg::bin_t        in_data_i,
  output logic                 job_valid_o,
  input  logic                 job_ready_i,
  output ebn_pkg::job_t        job_o
);
  typedef enum logic [1:0] {StIdle, StSq, StAdd, StJob} state_e;
  state_e state_q;
  logic [47:0] sq_re_q, sq_im_q, sum_q;
  logic [6:0] cnt_q;
  logic [ebn_pkg::BandW-1:0] band_q;
  logic fs_q;
  logic [23:0] re_q, im_q;
  logic [48:0] tot;
  logic [47:0] base;
  logic [6:0] cnt1, w;

  assign in_ready_o = (state_q == StIdle);
  assign job_valid_o = (state_q == StJob);
  assign base = fs_q ? 48'd0 : sum_q;
  assign tot = {1'b0, base} + {1'b0, sq_re_q} + {1'b0, sq_im_q};
  assign cnt1 = (fs_q ? 7'd0 : cnt_q) + 7'd1;
  assign w = ebn_pkg::band_width(fs_q ? '0 : band_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      sum_q <= '0;
      cnt_q <= '0;
      band_q <= '0;
      fs_q <= 1'b0;
    end else begin
      unique case (state_q)
        StIdle: if (in_valid_i) begin
          re_q <= in_data_i.bin_re;
          im_q <= in_data_i.bin_im;
          fs_q <= in_data_i.frame_start;
          state_q <= StSq;
        end
        StSq: begin
          sq_re_q <= 48'($signed(re_q) * $signed(re_q));
          sq_im_q <= 48'($signed(im_q) * $signed(im_q));
          state_q <= StAdd;
        end
        StAdd: begin
          sum_q <= tot[48] ? ebn_pkg::PowerMax : tot[47:0];
          if (fs_q) band_q <= '0;
          if (cnt1 >= w) begin
            cnt_q <= cnt1;
            state_q <= StJob;
          end else begin
            cnt_q <= cnt1;
            state_q <= StIdle;
          end
        end
        StJob: if (job_ready_i) begin
          sum_q <= '0;
          cnt_q <= '0;
          band_q <= (band_q == 5'(ebn_pkg::NumBands - 1)) ? '0 : band_q + 1'b1;
          state_q <= StIdle;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_comb begin
    job_o.band = band_q;
    job_o.power = sum_q;
    job_o.width = ebn_pkg::band_width(band_q);
    job_o.last = (band_q == 5'(ebn_pkg::NumBands - 1));
  end
endmodule

FILE: rtl/core/ebn_norm.sv
// ----------------------------------------------------------------------------
// ebn_norm
// Band mean, log, running-mean memory update and feature division.
// ----------------------------------------------------------------------------
`include "erb_band_feature_normalizer_unit_macros.svh"
module ebn_norm (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 job_valid_i,
  output logic                 job_ready_o,
  input  ebn_pkg::job_t        job_i,
  input  logic [15:0]          alpha_i,
  input  logic                 db_en_i,
  input  logic [7:0]           div_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output ebn_pkg::feat_t       out_o
);
  typedef enum logic [3:0] {
    StIdle, StClr, StDiv, StLogN, StLogSq, StLogChk, StDbMul, StX, StMul, StNm, StFdiv, StOut
  } state_e;
  state_e state_q;

  // Running mean memory, one read port, one write port, registered read.
  logic [15:0] mem_q [2**ebn_pkg::MeanAw];
  logic [15:0] rd_q;
  logic        we;
  logic [ebn_pkg::MeanAw-1:0] wa;
  logic [15:0] wd;
  logic [ebn_pkg::MeanAw-1:0] clr_q;

  logic [47:0] rem_q, quo_q;
  logic [6:0]  dcnt_q;
  logic [47:0] q;
  logic [5:0]  e_q;
  logic [31:0] y_q;
  logic [63:0] ysq_q;
  logic [4:0]  it_q;
  logic [15:0] f_q;
  logic signed [22:0] d_q;
  logic signed [41:0] prod_q;
  logic signed [15:0] x_q, nm;
  logic signed [33:0] aprod_q;
  logic signed [20:0] num_q;
  logic [20:0] mag_q, fq_q;
  logic        neg_q;
  logic [7:0]  dv_q;
  logic [4:0]  fcnt_q;
  ebn_pkg::job_t job_q;
  logic [5:0]  lz;
  logic [47:0] xs;
  logic signed [41:0] rnd;
  logic signed [17:0] diff;
  logic signed [33:0] arnd;
  logic [21:0] fres;

  assign job_ready_o = (state_q == StIdle);
  assign out_valid_o = (state_q == StOut);
  assign q = quo_q + ebn_pkg::EpsQ44;

  always_comb begin
    lz = '0;
    for (int i = 0; i < 48; i++) if (q[i]) lz = 6'(i);
  end
  assign xs = (lz >= 6'd30) ? (q >> (lz - 6'd30)) : (q << (6'd30 - lz));
  assign rnd = prod_q + 42'sd8388608;
  assign diff = 18'($signed(rd_q)) - 18'(x_q);
  assign arnd = aprod_q + 34'sd32768;

  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[job_q.band];
  end

  always_comb begin
    we = 1'b0;
    wa = job_q.band;
    wd = nm;
    if (state_q == StClr) begin
      we = 1'b1;
      wa = clr_q;
      wd = ebn_pkg::mean_reset(clr_q);
    end else if (state_q == StNm) begin
      we = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StClr;
      clr_q <= '0;
      it_q <= '0;
      fcnt_q <= '0;
    end else begin
      unique case (state_q)
        StClr: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == 5'(ebn_pkg::NumBands - 1)) state_q <= StIdle;
        end
        StIdle: if (job_valid_i) begin
          job_q <= job_i;
          quo_q <= job_i.power;
          rem_q <= '0;
          dcnt_q <= '0;
          it_q <= '0;
          dv_q <= (div_i == 8'd0) ? 8'd1 : div_i;
          state_q <= StDiv;
        end
        StDiv: begin
          // restoring divide, one quotient bit per cycle
          if ({rem_q, quo_q[47]} >= {42'd0, job_q.width}) begin
            rem_q <= 48'({rem_q, quo_q[47]} - {42'd0, job_q.width});
            quo_q <= {quo_q[46:0], 1'b1};
          end else begin
            rem_q <= {rem_q[46:0], quo_q[47]};
            quo_q <= {quo_q[46:0], 1'b0};
          end
          dcnt_q <= dcnt_q + 1'b1;
          if (dcnt_q == 7'd47) state_q <= db_en_i ? StLogN : StX;
        end
        StLogN: begin
          e_q <= lz;
          y_q <= xs[31:0];
          f_q <= '0;
          it_q <= '0;
          state_q <= StLogSq;
        end
        StLogSq: begin
          ysq_q <= 64'(y_q) * 64'(y_q);
          state_q <= StLogChk;
        end
        StLogChk: begin
          if (ysq_q[61]) begin
            y_q <= 32'(ysq_q >> 31);
            f_q[15 - it_q[3:0]] <= 1'b1;
          end else begin
            y_q <= 32'(ysq_q >> 30);
          end
          it_q <= it_q + 1'b1;
          state_q <= (it_q == 5'd15) ? StDbMul : StLogSq;
        end
        StDbMul: begin
          d_q <= $signed({1'b0, e_q, f_q}) - 23'sd2883584;
          state_q <= StMul;
          it_q <= '0;
        end
        StMul: begin
          if (it_q == 5'd0) begin
            prod_q <= d_q * $signed({1'b0, ebn_pkg::DbPerLog2Q16});
            it_q <= 5'd1;
          end else begin
            x_q <= ebn_pkg::clamp16(48'(rnd >>> 24));
            state_q <= StX;
            it_q <= '0;
          end
        end
        StX: begin
          if (!db_en_i && it_q == 5'd0) x_q <= ebn_pkg::clamp16({36'd0, quo_q[47:36]});
          if (it_q == 5'd0) begin
            it_q <= 5'd1;
          end else begin
            aprod_q <= $signed({1'b0, alpha_i}) * diff;
            it_q <= '0;
            state_q <= StNm;
          end
        end
        StNm: begin
          state_q <= StFdiv;
        end
        StFdiv: begin
          if (fcnt_q == 5'd0 && it_q == 5'd0) begin
            num_q <= (21'(x_q) - 21'(nm)) <<< 4;
            it_q <= 5'd1;
          end else if (it_q == 5'd1) begin
            neg_q <= num_q[20];
            mag_q <= num_q[20] ? 21'(-num_q) : 21'(num_q);
            fq_q <= '0;
            num_q <= '0;
            it_q <= 5'd2;
          end else begin
            if ({num_q[19:0], mag_q[20]} >= {13'd0, dv_q}) begin
              num_q <= {num_q[19:0], mag_q[20]} - {13'd0, dv_q};
              fq_q <= {fq_q[19:0], 1'b1};
            end else begin
              num_q <= {num_q[19:0], mag_q[20]};
              fq_q <= {fq_q[19:0], 1'b0};
            end
            mag_q <= {mag_q[19:0], 1'b0};
            fcnt_q <= fcnt_q + 1'b1;
            if (fcnt_q == 5'd20) begin
              fcnt_q <= '0;
              it_q <= '0;
              state_q <= StOut;
            end
          end
        end
        StOut: if (out_ready_i) state_q <= StIdle;
        default: state_q <= StIdle;
      endcase
      if (state_q == StIdle) fcnt_q <= '0;
    end
  end

  // new mean, from the registered alpha product
  always_comb begin
    nm = ebn_pkg::clamp16(48'(x_q) + 48'(arnd >>> 16));
  end

  assign fres = {1'b0, fq_q};
  always_comb begin
    out_o.band_index = job_q.band;
    out_o.last_band = job_q.last;
    out_o.band_feature = ebn_pkg::clamp16(neg_q ? -48'(fres) : 48'(fres));
  end

  `EBN_ASSERT(a_out_idle_excl, clk_i, rst_ni, !(out_valid_o && job_ready_o), "out while idle")
  `EBN_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && !out_ready_i) |=> out_valid_o, "drop")
  `EBN_ASSERT_NEVER(a_clr_job, clk_i, rst_ni, (state_q == StClr) && job_ready_o, "ready in clear")
endmodule

FILE: rtl/core/erb_band_feature_normalizer_unit.sv
// ----------------------------------------------------------------------------
// erb_band_feature_normalizer_unit
// ERB band log energy with exponential mean normalization.
// ----------------------------------------------------------------------------
// The accumulator squares and adds each bin before it accepts the next. A
// band then passes the 48-step mean divider, in dB mode the 16 log squarings,
// and the 21-step feature divider; a closing bin stalls input while the
// normalizer is busy.
// Reset: asynchronous, active low; then a pass loads the running-mean memory
// with its ramp, during which no closing band is finished.
`include "erb_band_feature_normalizer_unit_macros.svh"
module erb_band_feature_normalizer_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_we_i,
  input  logic [ebn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ebn_pkg::CfgDataW-1:0] cfg_data_i,
  ebn_stream_if.sink    bin_if,
  ebn_stream_if.source  feat_if
);
  logic [15:0] alpha_q;
  logic        db_en_q;
  logic [7:0]  div_q;
  logic        job_valid, job_ready;
  ebn_pkg::job_t job;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= 16'd64881;
      db_en_q <= 1'b1;
      div_q <= 8'd40;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ebn_pkg::CfgSmoothing: alpha_q <= cfg_data_i;
        ebn_pkg::CfgDbEnable: db_en_q <= cfg_data_i[0];
        ebn_pkg::CfgNormDiv: div_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  ebn_accum u_accum (
    .clk_i, .rst_ni,
    .in_valid_i(bin_if.valid), .in_ready_o(bin_if.ready), .in_data_i(bin_if.data),
    .job_valid_o(job_valid), .job_ready_i(job_ready), .job_o(job)
  );

  ebn_norm u_norm (
    .clk_i, .rst_ni,
    .job_valid_i(job_valid), .job_ready_o(job_ready), .job_i(job),
    .alpha_i(alpha_q), .db_en_i(db_en_q), .div_i(div_q),
    .out_valid_o(feat_if.valid), .out_ready_i(feat_if.ready), .out_o(feat_if.data)
  );

  `EBN_ASSERT(a_job_hold, clk_i, rst_ni, (job_valid && !job_ready) |=> job_valid, "job lost")
  `EBN_ASSERT_NEVER(a_band_range, clk_i, rst_ni, job_valid && job.width == 7'd0, "zero width")
  `EBN_ASSERT(a_last_band, clk_i, rst_ni, !(job_valid && job.last) || job.band == 5'd31, "last")
endmodule

FILE: dv/erb_band_feature_normalizer_unit_checker.sv
// ----------------------------------------------------------------------------
// erb_band_feature_normalizer_unit_checker
// Watches the bin and feature channels, predicts each band feature from the
// accepted bins and compares it field by field with the block's output.
// ----------------------------------------------------------------------------
module erb_band_feature_normalizer_unit_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [ebn_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ebn_pkg::CfgDataW-1:0] cfg_data_i,
  ebn_stream_if                        bin_if,
  ebn_stream_if                        feat_if,
  output int                           errors_o,
  output int                           pending_o
);
  logic [15:0]    alpha_q;
  logic           db_en_q;
  logic [7:0]     divisor_q;
  logic [47:0]    band_power_q;
  int             bins_seen_q;
  int             band_q;
  int             mean_q [ebn_pkg::NumBands];
  ebn_pkg::feat_t feature_fifo [$];

  function automatic longint round_shift(longint v, int sh);
    longint t;
    t = v + (longint'(1) << (sh - 1));
    return t >>> sh;
  endfunction

  function automatic longint sat16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic longint log2_fix16(logic [63:0] q);
    int          e;
    logic [63:0] y;
    logic [15:0] f;
    e = 0;
    f = '0;
    for (int i = 63; i >= 0; i--) begin
      if (q[i]) begin
        e = i;
        break;
      end
    end
    y = (e >= 30) ? (q >> (e - 30)) : (q << (30 - e));
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 30;
      if (y >= (64'd2 << 30)) begin
        y = y >> 1;
        f[15-i] = 1'b1;
      end
    end
    return (longint'(e) << 16) | longint'(f);
  endfunction

  // One bin in, at most one band feature out.
  task automatic predict_bin(ebn_pkg::bin_t b);
    longint         re, im, x, nm, ft;
    logic [63:0]    sum, m;
    int             w, dv;
    ebn_pkg::feat_t r;
    re = longint'(signed'(b.bin_re));
    im = longint'(signed'(b.bin_im));
    if (b.frame_start) begin
      band_power_q = '0;
      bins_seen_q = 0;
      band_q = 0;
    end
    sum = 64'(band_power_q) + 64'(re * re) + 64'(im * im);
    band_power_q = (sum > 64'(ebn_pkg::PowerMax)) ? ebn_pkg::PowerMax : sum[47:0];
    bins_seen_q++;
    w = ebn_pkg::band_width(5'(band_q));
    if (bins_seen_q < w) return;
    m = 64'(band_power_q) / w;
    if (db_en_q)
      x = sat16(round_shift((log2_fix16(m + 1759) - (longint'(44) << 16)) * 197284, 24));
    else
      x = sat16(longint'(m >> 36));
    nm = sat16(x + round_shift(longint'(alpha_q) * (mean_q[band_q] - x), 16));
    mean_q[band_q] = int'(nm);
    dv = (divisor_q == 0) ? 1 : divisor_q;
    ft = sat16(((x - nm) * 16) / dv);
    r.band_index = 5'(band_q);
    r.band_feature = 16'(ft);
    r.last_band = (band_q == ebn_pkg::NumBands - 1);
    feature_fifo = {feature_fifo, r};
    band_power_q = '0;
    bins_seen_q = 0;
    band_q = r.last_band ? 0 : band_q + 1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    ebn_pkg::feat_t got, want;
    if (!rst_ni) begin
      alpha_q = 16'd64881;
      db_en_q = 1'b1;
      divisor_q = 8'd40;
      band_power_q = '0;
      bins_seen_q = 0;
      band_q = 0;
      for (int i = 0; i < ebn_pkg::NumBands; i++)
        mean_q[i] = int'(signed'(ebn_pkg::mean_reset(5'(i))));
      feature_fifo.delete();
      errors_o = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          ebn_pkg::CfgSmoothing: alpha_q = cfg_data_i;
          ebn_pkg::CfgDbEnable:  db_en_q = cfg_data_i[0];
          ebn_pkg::CfgNormDiv:   divisor_q = cfg_data_i[7:0];
          default: ;
        endcase
      end
      if (feat_if.valid && feat_if.ready) begin
        got = feat_if.data;
        if (feature_fifo.size() == 0) begin
          $display("%0t: unexpected feature, actual %p", $time, got);
          errors_o++;
        end else begin
          want = feature_fifo.pop_front();
          if (got.band_index !== want.band_index || got.band_feature !== want.band_feature
              || got.last_band !== want.last_band) begin
            $display("%0t: feature mismatch, expected %p actual %p", $time, want, got);
            errors_o++;
          end
        end
      end
      if (bin_if.valid && bin_if.ready) predict_bin(bin_if.data);
    end
    pending_o = feature_fifo.size();
  end
endmodule

FILE: dv/erb_band_feature_normalizer_unit_test.sv
// ----------------------------------------------------------------------------
// erb_band_feature_normalizer_unit_test
// Drives spectrum bins and register writes into the normalizer with random
// idling on both channels; the checker predicts and compares every feature.
// ----------------------------------------------------------------------------
module erb_band_feature_normalizer_unit_test;
  localparam int FrameBins = 481;
  localparam int RandBins = 1517;
  // index with no register behind it
  localparam logic [ebn_pkg::CfgIdxW-1:0] CfgUnknown = 2'd3;

  logic                         clk_i = 1'b0;
  logic                         rst_ni = 1'b0;
  logic                         cfg_we_i = 1'b0;
  logic [ebn_pkg::CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [ebn_pkg::CfgDataW-1:0] cfg_data_i = '0;
  int                           errors;
  int                           pending;
  bit                           hold_sink = 1'b0;  // long receiver hold-off request

  ebn_stream_if #(.T(ebn_pkg::bin_t))  bin_if ();
  ebn_stream_if #(.T(ebn_pkg::feat_t)) feat_if ();

  always #10 clk_i = ~clk_i;

  erb_band_feature_normalizer_unit dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .bin_if(bin_if.sink), .feat_if(feat_if.source)
  );

  erb_band_feature_normalizer_unit_checker u_checker (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .bin_if, .feat_if, .errors_o(errors), .pending_o(pending)
  );

  initial begin
    bin_if.valid = 1'b0;
    bin_if.data = '0;
    feat_if.ready = 1'b0;
  end

  // Mostly short gaps, now and then a long one, with stretches of none.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 150);
  endfunction

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    int n;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_sink) begin
        feat_if.ready <= 1'b0;
        n = 0;
        while (n < 3000) begin
          @(posedge clk_i);
          n++;
        end
        hold_sink = 1'b0;
      end else begin
        n = gap_len();
        feat_if.ready <= (n == 0);
        repeat (n) @(posedge clk_i);
        if (n != 0) feat_if.ready <= 1'b1;
      end
    end
  end

  // Sends one bin transaction, idling first; valid stays high on back-to-back.
  task automatic send_bin(logic [23:0] re, logic [23:0] im, logic fs);
    int g;
    g = gap_len();
    if (g != 0) begin
      bin_if.valid <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    bin_if.valid <= 1'b1;
    bin_if.data <= '{bin_re: re, bin_im: im, frame_start: fs};
    do @(posedge clk_i); while (!bin_if.ready);
  endtask

  // Waits until every predicted feature has been received.
  task automatic drain();
    bin_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [ebn_pkg::CfgIdxW-1:0] idx,
                           logic [ebn_pkg::CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Random bin: small, mid or full scale magnitudes.
  function automatic logic [23:0] rand_part();
    case ($urandom_range(0, 3))
      0: return 24'($signed($urandom_range(0, 64)) - 32);
      1: return 24'($urandom_range(0, 32'hFFFF) - 32'h8000);
      2: return ($urandom_range(0, 1)) ? 24'h7FFFFF : 24'h800000;
      default: return 24'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: extremes, mid-frame restart, zero divisor, linear mode.
    send_bin(24'h7FFFFF, 24'h7FFFFF, 1'b1);
    send_bin(24'h800000, 24'h800000, 1'b0);
    send_bin(24'h000000, 24'h000000, 1'b0);
    send_bin(24'h000000, 24'h000000, 1'b0);
    send_bin(24'h000001, 24'hFFFFFF, 1'b0);
    send_bin(24'h400000, 24'hC00000, 1'b1);
    send_bin(24'h800000, 24'h7FFFFF, 1'b0);
    drain();
    write_reg(ebn_pkg::CfgNormDiv, 16'd0);
    write_reg(ebn_pkg::CfgSmoothing, 16'd0);
    write_reg(ebn_pkg::CfgDbEnable, 16'd0);
    write_reg(CfgUnknown, 16'hFFFF);
    send_bin(24'h7FFFFF, 24'h800000, 1'b1);
    send_bin(24'h7FFFFF, 24'h7FFFFF, 1'b0);
    send_bin(24'h000000, 24'h000000, 1'b0);
    send_bin(24'h000000, 24'h000000, 1'b0);
    drain();
    write_reg(ebn_pkg::CfgSmoothing, 16'hFFFF);
    write_reg(ebn_pkg::CfgNormDiv, 16'd255);
    write_reg(ebn_pkg::CfgDbEnable, 16'd1);
    send_bin(24'h123456, 24'hEDCBA9, 1'b1);
    send_bin(24'h000000, 24'h000001, 1'b0);
    drain();

    // Random: mostly whole frames, occasional restarts, config between phases.
    sent = 0;
    for (int ph = 0; ph < 4; ph++) begin
      if (ph == 1) hold_sink = 1'b1;
      for (int k = 0; k < FrameBins && sent < RandBins; k++) begin
        send_bin(rand_part(), rand_part(), (k == 0) || ($urandom_range(0, 299) == 0));
        sent++;
      end
      if (ph == 2) begin
        // last frame of the phase wraps with no frame start
        for (int k = 0; k < 20; k++) send_bin(rand_part(), rand_part(), 1'b0);
      end
      drain();
      write_reg(ebn_pkg::CfgSmoothing, 16'($urandom));
      write_reg(ebn_pkg::CfgDbEnable, 16'($urandom_range(0, 1)));
      write_reg(ebn_pkg::CfgNormDiv, 16'($urandom_range(1, 255)));
    end
    drain();
    if (errors == 0) begin
      $display("[erb_band_feature_normalizer_unit] OK");
    end else begin
      $display("[erb_band_feature_normalizer_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #100000000;
    $display("[erb_band_feature_normalizer_unit] ERROR");
    $finish;
  end
endmodule
